/* rtl/rri_pkg.sv */
// Shared types, constants and codes for the ray / rectangle intersection block.
package rri_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned TexW    = 17;
  localparam int unsigned NormW   = 3;
  localparam int unsigned MatW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned TQBits  = 32;  // magnitude bits of the crossing parameter
  localparam int unsigned UVBits  = 17;  // quotient bits of a texture fraction
  localparam int unsigned FracSh  = 16;  // Q16.16 binary point

  typedef enum logic [1:0] {
    AXIS_Z = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_X = 2'd2
  } axis_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PLANE_AXIS   = 3'd0,
    REG_PLANE_OFFSET = 3'd1,
    REG_LOW_A        = 3'd2,
    REG_HIGH_A       = 3'd3,
    REG_LOW_B        = 3'd4,
    REG_HIGH_B       = 3'd5,
    REG_FLIP_NORMAL  = 3'd6,
    REG_MATERIAL_ID  = 3'd7
  } reg_idx_e;

  localparam logic [NormW-1:0] NormFlipOfs = 3'd3;
  localparam logic [CoordW-1:0] OneQ16     = 32'h0001_0000;

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic signed [CoordW-1:0] origin_z;
    logic signed [CoordW-1:0] dir_x;
    logic signed [CoordW-1:0] dir_y;
    logic signed [CoordW-1:0] dir_z;
    logic signed [CoordW-1:0] t_lower;
    logic signed [CoordW-1:0] t_upper;
  } ray_t;

  // carried alongside the crossing-parameter divider
  typedef struct packed {
    ray_t ray;
    logic miss;
    logic neg;
  } tdiv_pl_t;

  // carried alongside the u divider
  typedef struct packed {
    logic              hit;
    logic [CoordW-1:0] t;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    logic [CoordW-1:0] pz;
    logic              degen_a;
  } udiv_pl_t;

  typedef struct packed {
    logic              hit_flag;
    logic [CoordW-1:0] hit_t;
    logic [TexW-1:0]   tex_u;
    logic [TexW-1:0]   tex_v;
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic [CoordW-1:0] point_z;
    logic [NormW-1:0]  normal_code;
    logic [MatW-1:0]   hit_material;
  } res_t;

  // saturate a 49-bit signed value to 32 bits signed
  function automatic logic [CoordW-1:0] sat49(input logic [48:0] v);
    logic ovf;
    begin
      ovf = !((v[48:31] == '0) || (v[48:31] == '1));
      if (!ovf) sat49 = v[CoordW-1:0];
      else if (v[48]) sat49 = 32'h8000_0000;
      else sat49 = 32'h7FFF_FFFF;
    end
  endfunction

endpackage

/* rtl/rri_div_pipe.sv */
// Pipelined restoring divider: one quotient bit per register stage, payload rides along.
module rri_div_pipe #(
  parameter int unsigned QBITS = 32,
  parameter int unsigned PW    = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [31:0]      rem_i,    // partial remainder, below den_i
  input  logic [QBITS-1:0] nbits_i,  // dividend bits still to shift in, MSB first
  input  logic [31:0]      den_i,
  input  logic [PW-1:0]    pl_i,
  output logic             valid_o,
  output logic [QBITS-1:0] quo_o,
  output logic [PW-1:0]    pl_o
);

  logic             v_q   [QBITS];
  logic [31:0]      rem_q [QBITS];
  logic [QBITS-1:0] nb_q  [QBITS];
  logic [QBITS-1:0] quo_q [QBITS];
  logic [31:0]      den_q [QBITS];
  logic [PW-1:0]    pl_q  [QBITS];

  for (genvar s = 0; s < QBITS; s++) begin : g_stage
    logic             v_prev;
    logic [31:0]      rem_prev;
    logic [QBITS-1:0] nb_prev;
    logic [QBITS-1:0] quo_prev;
    logic [31:0]      den_prev;
    logic [PW-1:0]    pl_prev;
    logic [32:0]      r2;
    logic [32:0]      diff;
    logic             ge;
    logic [31:0]      rem_d;

    if (s == 0) begin : g_first
      assign v_prev   = valid_i;
      assign rem_prev = rem_i;
      assign nb_prev  = nbits_i;
      assign quo_prev = '0;
      assign den_prev = den_i;
      assign pl_prev  = pl_i;
    end else begin : g_next
      assign v_prev   = v_q[s-1];
      assign rem_prev = rem_q[s-1];
      assign nb_prev  = nb_q[s-1];
      assign quo_prev = quo_q[s-1];
      assign den_prev = den_q[s-1];
      assign pl_prev  = pl_q[s-1];
    end

    always_comb begin
      r2    = {rem_prev, nb_prev[QBITS-1]};
      diff  = r2 - {1'b0, den_prev};
      ge    = (r2 >= {1'b0, den_prev});
      rem_d = ge ? diff[31:0] : r2[31:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        nb_q[s]  <= {nb_prev[QBITS-2:0], 1'b0};
        quo_q[s] <= {quo_prev[QBITS-2:0], ge};
        den_q[s] <= den_prev;
        pl_q[s]  <= pl_prev;
      end
    end
  end

  assign valid_o = v_q[QBITS-1];
  assign quo_o   = quo_q[QBITS-1];
  assign pl_o    = pl_q[QBITS-1];

endmodule

/* rtl/rri_skid.sv */
// Two-entry output buffer: output register plus skid register.
module rri_skid #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [DW-1:0] in_data_i,
  output logic          ready_o,
  output logic          out_valid_o,
  output logic [DW-1:0] out_data_o,
  input  logic          out_stall_i
);

  logic          out_v_q, sk_v_q;
  logic [DW-1:0] out_d_q, sk_d_q;
  logic          free;

  assign free    = !out_v_q || !out_stall_i;
  assign ready_o = !sk_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (free) begin
      out_v_q <= sk_v_q || in_valid_i;
      sk_v_q  <= sk_v_q && in_valid_i;
    end else if (in_valid_i) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free) begin
      out_d_q <= sk_v_q ? sk_d_q : in_data_i;
      if (in_valid_i) sk_d_q <= in_data_i;
    end else if (in_valid_i) begin
      sk_d_q <= in_data_i;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_d_q;

endmodule

/* rtl/ray_rectangle_intersect.sv */
// Ray versus axis-aligned rectangle intersection, pipelined top level.
//
//  channel  direction  handshake                 payload
//  in       to block   in_valid_i / in_stall_o   origin, dir, t_lower, t_upper
//  out      from block out_valid_o / out_stall_i hit flag, t, u, v, point, normal, material
//  cfg      to block   cfg_we_i                  cfg_index_i, cfg_data_i
//
// One ray per cycle sustained while in_stall_o is low; 58 register stages from the input
// transfer to out_valid_o: 3 setup stages, 32 stages of the crossing divider, 5 geometry stages,
// 17 stages of the u/v dividers feeding the combinational result logic, the output register.
// Reset clears valid bits and restores the register defaults.
// The whole pipe holds while the skid register is full; in_stall_o is that flag.
module ray_rectangle_intersect (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rri_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rri_pkg::CoordW-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [rri_pkg::CoordW-1:0] origin_x_i,
  input  logic signed [rri_pkg::CoordW-1:0] origin_y_i,
  input  logic signed [rri_pkg::CoordW-1:0] origin_z_i,
  input  logic signed [rri_pkg::CoordW-1:0] dir_x_i,
  input  logic signed [rri_pkg::CoordW-1:0] dir_y_i,
  input  logic signed [rri_pkg::CoordW-1:0] dir_z_i,
  input  logic signed [rri_pkg::CoordW-1:0] t_lower_i,
  input  logic signed [rri_pkg::CoordW-1:0] t_upper_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           hit_flag_o,
  output logic signed [rri_pkg::CoordW-1:0] hit_t_o,
  output logic [rri_pkg::TexW-1:0]       tex_u_o,
  output logic [rri_pkg::TexW-1:0]       tex_v_o,
  output logic signed [rri_pkg::CoordW-1:0] point_x_o,
  output logic signed [rri_pkg::CoordW-1:0] point_y_o,
  output logic signed [rri_pkg::CoordW-1:0] point_z_o,
  output logic [rri_pkg::NormW-1:0]      normal_code_o,
  output logic [rri_pkg::MatW-1:0]       hit_material_o
);
  import rri_pkg::*;

  // configuration registers
  logic [1:0]        plane_axis_q;
  logic [CoordW-1:0] plane_offset_q, low_a_q, high_a_q, low_b_q, high_b_q;
  logic              flip_normal_q;
  logic [MatW-1:0]   material_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_axis_q   <= AXIS_Z;
      plane_offset_q <= '0;
      low_a_q        <= '0;
      high_a_q       <= OneQ16;
      low_b_q        <= '0;
      high_b_q       <= OneQ16;
      flip_normal_q  <= 1'b0;
      material_id_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PLANE_AXIS:   plane_axis_q   <= cfg_data_i[1:0];
        REG_PLANE_OFFSET: plane_offset_q <= cfg_data_i;
        REG_LOW_A:        low_a_q        <= cfg_data_i;
        REG_HIGH_A:       high_a_q       <= cfg_data_i;
        REG_LOW_B:        low_b_q        <= cfg_data_i;
        REG_HIGH_B:       high_b_q       <= cfg_data_i;
        REG_FLIP_NORMAL:  flip_normal_q  <= cfg_data_i[0];
        REG_MATERIAL_ID:  material_id_q  <= cfg_data_i[MatW-1:0];
        default: ;
      endcase
    end
  end

  logic en;       // global pipe advance
  logic skid_ready;
  assign en         = skid_ready;
  assign in_stall_o = !en;

  // ---- stage 1: input register
  logic s1_v_q;
  ray_t s1_ray_q;

  // ---- stage 2: normal-axis select and numerator
  logic              s2_v_q, s2_miss_q;
  ray_t              s2_ray_q;
  logic [32:0]       s2_num_q;
  logic [CoordW-1:0] s2_dn_q;
  logic [CoordW-1:0] on, dn;
  logic              bad_axis;
  logic [32:0]       num;

  always_comb begin
    bad_axis = 1'b0;
    unique case (plane_axis_q)
      AXIS_Z: begin on = s1_ray_q.origin_z; dn = s1_ray_q.dir_z; end
      AXIS_Y: begin on = s1_ray_q.origin_y; dn = s1_ray_q.dir_y; end
      AXIS_X: begin on = s1_ray_q.origin_x; dn = s1_ray_q.dir_x; end
      default: begin on = '0; dn = '0; bad_axis = 1'b1; end
    endcase
    num = {plane_offset_q[CoordW-1], plane_offset_q} - {on[CoordW-1], on};
  end

  // ---- stage 3: magnitudes, sign and quotient overflow
  logic              s3_v_q, s3_miss_q, s3_neg_q;
  ray_t              s3_ray_q;
  logic [32:0]       s3_absn_q;
  logic [CoordW-1:0] s3_absd_q;
  logic [32:0]       absn;
  logic [CoordW-1:0] absd;
  logic              ovf;

  always_comb begin
    absn = s2_num_q[32] ? (33'd0 - s2_num_q) : s2_num_q;
    absd = s2_dn_q[CoordW-1] ? (32'd0 - s2_dn_q) : s2_dn_q;
    // quotient magnitude of 2^32 or more cannot land in a 32-bit interval
    ovf  = ({15'd0, absn} >= {absd, 16'd0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ray_q  <= '{origin_x_i, origin_y_i, origin_z_i, dir_x_i, dir_y_i, dir_z_i,
                     t_lower_i, t_upper_i};
      s2_ray_q  <= s1_ray_q;
      s2_num_q  <= num;
      s2_dn_q   <= dn;
      s2_miss_q <= bad_axis || (dn == '0);
      s3_ray_q  <= s2_ray_q;
      s3_absn_q <= absn;
      s3_absd_q <= absd;
      s3_neg_q  <= s2_num_q[32] ^ s2_dn_q[CoordW-1];
      s3_miss_q <= s2_miss_q || ovf;
    end
  end

  // ---- crossing-parameter divider
  tdiv_pl_t          td_pl_in, td_pl_out;
  logic              td_v;
  logic [TQBits-1:0] td_q;

  assign td_pl_in = '{ray: s3_ray_q, miss: s3_miss_q, neg: s3_neg_q};

  rri_div_pipe #(
    .QBITS(TQBits),
    .PW   ($bits(tdiv_pl_t))
  ) u_tdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s3_v_q),
    .rem_i  ({15'd0, s3_absn_q[32:16]}),
    .nbits_i({s3_absn_q[15:0], 16'd0}),
    .den_i  (s3_absd_q),
    .pl_i   (td_pl_in),
    .valid_o(td_v),
    .quo_o  (td_q),
    .pl_o   (td_pl_out)
  );

  // ---- stage 4: signed t
  logic        s4_v_q, s4_miss_q;
  ray_t        s4_ray_q;
  logic [32:0] s4_t_q;

  // ---- stage 5: interval test
  logic              s5_v_q, s5_miss_q;
  ray_t              s5_ray_q;
  logic [CoordW-1:0] s5_t_q;
  logic              in_int;

  always_comb begin
    in_int = ($signed(s4_t_q) >= $signed({s4_ray_q.t_lower[CoordW-1], s4_ray_q.t_lower}))
          && ($signed(s4_t_q) <= $signed({s4_ray_q.t_upper[CoordW-1], s4_ray_q.t_upper}));
  end

  // ---- stage 6: products t * dir
  logic              s6_v_q, s6_miss_q;
  ray_t              s6_ray_q;
  logic [CoordW-1:0] s6_t_q;
  logic [63:0]       s6_px_q, s6_py_q, s6_pz_q;

  // ---- stage 7: hit point at full width
  logic              s7_v_q, s7_miss_q;
  logic [CoordW-1:0] s7_t_q;
  logic [48:0]       s7_x_q, s7_y_q, s7_z_q;

  function automatic logic [48:0] add_pt(input logic [CoordW-1:0] o, input logic [63:0] pr);
    add_pt = {{17{o[CoordW-1]}}, o} + {pr[63], pr[63:FracSh]};
  endfunction

  // ---- stage 8: bounds, fraction operands, saturation
  logic              s8_v_q, s8_hit_q, s8_dga_q, s8_dgb_q;
  logic [CoordW-1:0] s8_t_q, s8_x_q, s8_y_q, s8_z_q;
  logic [CoordW-1:0] s8_xa_q, s8_xb_q, s8_spa_q, s8_spb_q;
  logic [48:0]       pa, pb;
  logic [32:0]       spa, spb;
  logic              in_box;

  always_comb begin
    unique case (plane_axis_q)
      AXIS_Z:  begin pa = s7_x_q; pb = s7_y_q; end
      AXIS_Y:  begin pa = s7_x_q; pb = s7_z_q; end
      AXIS_X:  begin pa = s7_y_q; pb = s7_z_q; end
      default: begin pa = s7_x_q; pb = s7_y_q; end
    endcase
    in_box = ($signed(pa) >= $signed({{17{low_a_q[CoordW-1]}}, low_a_q}))
          && ($signed(pa) <= $signed({{17{high_a_q[CoordW-1]}}, high_a_q}))
          && ($signed(pb) >= $signed({{17{low_b_q[CoordW-1]}}, low_b_q}))
          && ($signed(pb) <= $signed({{17{high_b_q[CoordW-1]}}, high_b_q}));
    spa = {high_a_q[CoordW-1], high_a_q} - {low_a_q[CoordW-1], low_a_q};
    spb = {high_b_q[CoordW-1], high_b_q} - {low_b_q[CoordW-1], low_b_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
      s8_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= td_v;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
      s7_v_q <= s6_v_q;
      s8_v_q <= s7_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_ray_q  <= td_pl_out.ray;
      s4_miss_q <= td_pl_out.miss;
      s4_t_q    <= td_pl_out.neg ? (33'd0 - {1'b0, td_q}) : {1'b0, td_q};

      s5_ray_q  <= s4_ray_q;
      s5_miss_q <= s4_miss_q || !in_int;
      s5_t_q    <= s4_t_q[CoordW-1:0];

      s6_ray_q  <= s5_ray_q;
      s6_miss_q <= s5_miss_q;
      s6_t_q    <= s5_t_q;
      s6_px_q   <= 64'($signed(s5_t_q) * $signed(s5_ray_q.dir_x));
      s6_py_q   <= 64'($signed(s5_t_q) * $signed(s5_ray_q.dir_y));
      s6_pz_q   <= 64'($signed(s5_t_q) * $signed(s5_ray_q.dir_z));

      s7_miss_q <= s6_miss_q;
      s7_t_q    <= s6_t_q;
      s7_x_q    <= add_pt(s6_ray_q.origin_x, s6_px_q);
      s7_y_q    <= add_pt(s6_ray_q.origin_y, s6_py_q);
      s7_z_q    <= add_pt(s6_ray_q.origin_z, s6_pz_q);

      s8_hit_q  <= !s7_miss_q && in_box;
      s8_t_q    <= s7_t_q;
      s8_x_q    <= sat49(s7_x_q);
      s8_y_q    <= sat49(s7_y_q);
      s8_z_q    <= sat49(s7_z_q);
      s8_xa_q   <= pa[CoordW-1:0] - low_a_q;
      s8_xb_q   <= pb[CoordW-1:0] - low_b_q;
      s8_spa_q  <= spa[CoordW-1:0];
      s8_spb_q  <= spb[CoordW-1:0];
      s8_dga_q  <= (spa == '0);
      s8_dgb_q  <= (spb == '0);
    end
  end

  // ---- texture fraction dividers, u and v side by side
  udiv_pl_t          ud_pl_in, ud_pl_out;
  logic              ud_v, vd_v, vd_dgb;
  logic [UVBits-1:0] ud_q, vd_q;

  assign ud_pl_in = '{hit: s8_hit_q, t: s8_t_q, px: s8_x_q, py: s8_y_q, pz: s8_z_q,
                      degen_a: s8_dga_q};

  rri_div_pipe #(
    .QBITS(UVBits),
    .PW   ($bits(udiv_pl_t))
  ) u_udiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s8_v_q),
    .rem_i  ({1'b0, s8_xa_q[CoordW-1:1]}),
    .nbits_i({s8_xa_q[0], 16'd0}),
    .den_i  (s8_spa_q),
    .pl_i   (ud_pl_in),
    .valid_o(ud_v),
    .quo_o  (ud_q),
    .pl_o   (ud_pl_out)
  );

  rri_div_pipe #(
    .QBITS(UVBits),
    .PW   (1)
  ) u_vdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s8_v_q),
    .rem_i  ({1'b0, s8_xb_q[CoordW-1:1]}),
    .nbits_i({s8_xb_q[0], 16'd0}),
    .den_i  (s8_spb_q),
    .pl_i   (s8_dgb_q),
    .valid_o(vd_v),
    .quo_o  (vd_q),
    .pl_o   (vd_dgb)
  );

  // ---- result stage
  res_t res, out_res;

  always_comb begin
    res = '0;
    if (ud_pl_out.hit) begin
      res.hit_flag     = 1'b1;
      res.hit_t        = ud_pl_out.t;
      res.tex_u        = ud_pl_out.degen_a ? '0 : ud_q;
      res.tex_v        = vd_dgb ? '0 : vd_q;
      res.point_x      = ud_pl_out.px;
      res.point_y      = ud_pl_out.py;
      res.point_z      = ud_pl_out.pz;
      res.normal_code  = {1'b0, plane_axis_q} + (flip_normal_q ? NormFlipOfs : '0);
      res.hit_material = material_id_q;
    end
  end

  rri_skid #(
    .DW($bits(res_t))
  ) u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (ud_v && vd_v && en),
    .in_data_i  (res),
    .ready_o    (skid_ready),
    .out_valid_o(out_valid_o),
    .out_data_o (out_res),
    .out_stall_i(out_stall_i)
  );

  assign hit_flag_o     = out_res.hit_flag;
  assign hit_t_o        = out_res.hit_t;
  assign tex_u_o        = out_res.tex_u;
  assign tex_v_o        = out_res.tex_v;
  assign point_x_o      = out_res.point_x;
  assign point_y_o      = out_res.point_y;
  assign point_z_o      = out_res.point_z;
  assign normal_code_o  = out_res.normal_code;
  assign hit_material_o = out_res.hit_material;

  // skid full means a result is waiting at the output
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // u and v dividers run in lockstep
  a_uv_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ud_v == vd_v)
    else $error("texture dividers out of step");

  // a miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_flag_o |-> hit_t_o == '0 && tex_u_o == '0 && tex_v_o == '0
      && normal_code_o == '0 && hit_material_o == '0)
    else $error("miss result with nonzero fields");

  // fractions stay within one
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_flag_o |-> tex_u_o <= 17'h1_0000 && tex_v_o <= 17'h1_0000)
    else $error("texture fraction above one");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the ray / axis-aligned rectangle intersection block.
`timescale 1ns / 1ps

module testbench;
  import rri_pkg::*;

  localparam int PipeDepth = 59;
  localparam int StallLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CoordW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CoordW-1:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [CoordW-1:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic signed [CoordW-1:0] t_lower_i = '0, t_upper_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_flag_o;
  logic signed [CoordW-1:0] hit_t_o, point_x_o, point_y_o, point_z_o;
  logic [TexW-1:0] tex_u_o, tex_v_o;
  logic [NormW-1:0] normal_code_o;
  logic [MatW-1:0] hit_material_o;

  ray_rectangle_intersect DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // rectangle setup as last written to the block
  logic [1:0] rect_axis;
  longint rect_ofs, rect_la, rect_ha, rect_lb, rect_hb;
  logic rect_flip;
  logic [MatW-1:0] rect_mat;

  res_t hits_pending[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic longint sat_coord(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [TexW-1:0] tex_frac(longint x, longint lo, longint hi);
    if (hi - lo <= 0) return '0;
    return TexW'(((x - lo) * 65536) / (hi - lo));
  endfunction

  // axis roles: normal, first and second in-plane axes
  function automatic void plane_roles(logic [1:0] ax, output int n, output int ia,
                                      output int ib);
    case (ax)
      AXIS_Y: begin n = 1; ia = 0; ib = 2; end
      AXIS_X: begin n = 0; ia = 1; ib = 2; end
      default: begin n = 2; ia = 0; ib = 1; end
    endcase
  endfunction

  function automatic res_t intersect_rect(ray_t r);
    res_t res;
    longint o[3], d[3], p[3];
    longint t;
    int n, ia, ib;
    res = '0;
    o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
    d[0] = r.dir_x; d[1] = r.dir_y; d[2] = r.dir_z;
    if (rect_axis == 2'd3) return res;
    plane_roles(rect_axis, n, ia, ib);
    if (d[n] == 0) return res;
    t = ((rect_ofs - o[n]) * 65536) / d[n];
    if (t < longint'(r.t_lower) || t > longint'(r.t_upper)) return res;
    for (int i = 0; i < 3; i++) p[i] = o[i] + ((t * d[i]) >>> 16);
    if (p[ia] < rect_la || p[ia] > rect_ha || p[ib] < rect_lb || p[ib] > rect_hb)
      return res;
    res.hit_flag = 1'b1;
    res.hit_t = t[31:0];
    res.tex_u = tex_frac(p[ia], rect_la, rect_ha);
    res.tex_v = tex_frac(p[ib], rect_lb, rect_hb);
    res.point_x = 32'(sat_coord(p[0]));
    res.point_y = 32'(sat_coord(p[1]));
    res.point_z = 32'(sat_coord(p[2]));
    res.normal_code = NormW'(rect_axis) + (rect_flip ? NormFlipOfs : '0);
    res.hit_material = rect_mat;
    return res;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hits_pending.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        want = hits_pending.pop_front();
        if (hit_flag_o !== want.hit_flag) begin
          $error("hit_flag exp %0d got %0d", want.hit_flag, hit_flag_o); errors++;
        end
        if (hit_t_o !== want.hit_t) begin
          $error("hit_t exp %0d got %0d", $signed(want.hit_t), hit_t_o); errors++;
        end
        if (tex_u_o !== want.tex_u) begin
          $error("tex_u exp %0d got %0d", want.tex_u, tex_u_o); errors++;
        end
        if (tex_v_o !== want.tex_v) begin
          $error("tex_v exp %0d got %0d", want.tex_v, tex_v_o); errors++;
        end
        if (point_x_o !== want.point_x) begin
          $error("point_x exp %0d got %0d", $signed(want.point_x), point_x_o); errors++;
        end
        if (point_y_o !== want.point_y) begin
          $error("point_y exp %0d got %0d", $signed(want.point_y), point_y_o); errors++;
        end
        if (point_z_o !== want.point_z) begin
          $error("point_z exp %0d got %0d", $signed(want.point_z), point_z_o); errors++;
        end
        if (normal_code_o !== want.normal_code) begin
          $error("normal_code exp %0d got %0d", want.normal_code, normal_code_o); errors++;
        end
        if (hit_material_o !== want.hit_material) begin
          $error("hit_material exp %0d got %0d", want.hit_material, hit_material_o);
          errors++;
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  // watchdog on cycles without any transfer
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL ray_rectangle_intersect");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [CoordW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_PLANE_AXIS: rect_axis = val[1:0];
      REG_PLANE_OFFSET: rect_ofs = $signed(val);
      REG_LOW_A: rect_la = $signed(val);
      REG_HIGH_A: rect_ha = $signed(val);
      REG_LOW_B: rect_lb = $signed(val);
      REG_HIGH_B: rect_hb = $signed(val);
      REG_FLIP_NORMAL: rect_flip = val[0];
      default: rect_mat = val[MatW-1:0];
    endcase
  endtask

  task automatic set_rect(logic [1:0] ax, longint ofs, longint la, longint ha,
                          longint lb, longint hb, logic flip, logic [MatW-1:0] mat);
    write_reg(REG_PLANE_AXIS, 32'(ax));
    write_reg(REG_PLANE_OFFSET, ofs[31:0]);
    write_reg(REG_LOW_A, la[31:0]);
    write_reg(REG_HIGH_A, ha[31:0]);
    write_reg(REG_LOW_B, lb[31:0]);
    write_reg(REG_HIGH_B, hb[31:0]);
    write_reg(REG_FLIP_NORMAL, 32'(flip));
    write_reg(REG_MATERIAL_ID, 32'(mat));
  endtask

  task automatic send_ray(ray_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    {origin_x_i, origin_y_i, origin_z_i, dir_x_i, dir_y_i, dir_z_i, t_lower_i, t_upper_i} = r;
    do @(posedge clk_i); while (in_stall_o);
    hits_pending.push_back(intersect_rect(r));
  endtask

  task automatic drain;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (hits_pending.size() == 0);
    repeat (PipeDepth + 10) @(posedge clk_i);
  endtask

  function automatic ray_t mk_ray(longint ox, oy, oz, dx, dy, dz, tl, tu);
    ray_t r;
    r.origin_x = ox[31:0]; r.origin_y = oy[31:0]; r.origin_z = oz[31:0];
    r.dir_x = dx[31:0]; r.dir_y = dy[31:0]; r.dir_z = dz[31:0];
    r.t_lower = tl[31:0]; r.t_upper = tu[31:0];
    return r;
  endfunction

  function automatic ray_t noise_ray();
    return mk_ray($signed($urandom), $signed($urandom), $signed($urandom),
                  $signed($urandom), $signed($urandom), $signed($urandom),
                  $signed($urandom), $signed($urandom));
  endfunction

  // ray aimed at a point on or near the rectangle, crossing at a known t
  function automatic ray_t aimed_ray();
    longint o[3], d[3], tgt[3];
    longint tt, tl, tu;
    int n, ia, ib;
    plane_roles(rect_axis, n, ia, ib);
    tt = $urandom_range(0, 20 << 16);
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'($urandom_range(0, 8 << 16)) - (4 << 16);
      if ($urandom_range(9) == 0) d[i] = 0;
    end
    if (d[n] == 0 && $urandom_range(9) != 0) d[n] = 65536;
    tgt[n] = rect_ofs;
    tgt[ia] = (rect_ha > rect_la) ?
              rect_la + ((rect_ha - rect_la) * $urandom_range(0, 70000)) / 65536 : rect_la;
    tgt[ib] = (rect_hb > rect_lb) ?
              rect_lb + ((rect_hb - rect_lb) * $urandom_range(0, 70000)) / 65536 : rect_lb;
    for (int i = 0; i < 3; i++) o[i] = tgt[i] - ((tt * d[i]) >>> 16);
    tl = tt - $urandom_range(0, 3 << 16);
    tu = tt + $urandom_range(0, 3 << 16);
    if ($urandom_range(9) == 0) begin
      tl = tt + 1; tu = tt - 1;
    end
    return mk_ray(o[0], o[1], o[2], d[0], d[1], d[2], tl, tu);
  endfunction

  task automatic random_rect();
    longint la, ha, lb, hb, ofs;
    logic [1:0] ax;
    ax = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    ofs = longint'($urandom_range(0, 40 << 16)) - (20 << 16);
    la = longint'($urandom_range(0, 20 << 16)) - (10 << 16);
    lb = longint'($urandom_range(0, 20 << 16)) - (10 << 16);
    ha = la + $urandom_range(1, 10 << 16);
    hb = lb + $urandom_range(1, 10 << 16);
    case ($urandom_range(9))
      0: begin la = -64'sd2147483648; ha = 64'sd2147483647; end
      1: ha = la;
      2: begin hb = lb - 5; end
      3: ofs = ($urandom_range(1)) ? 64'sd2147483647 : -64'sd2147483648;
      default: ;
    endcase
    set_rect(ax, ofs, la, ha, lb, hb, 1'($urandom), 16'($urandom));
  endtask

  task automatic test_reset_defaults;
    // unit square in the xy plane at z = 0
    send_ray(mk_ray(32768, 32768, 65536, 0, 0, -65536, 0, 2 << 16));
    send_ray(mk_ray(32768, 32768, 65536, 0, 0, -65536, 65536, 65536));
    send_ray(mk_ray(32768, 32768, 65536, 0, 0, -65536, 65537, 2 << 16));
    send_ray(mk_ray(0, 0, 65536, 0, 0, -65536, 0, 65536));
    send_ray(mk_ray(65536, 65536, 65536, 0, 0, -65536, 0, 65536));
    send_ray(mk_ray(65537, 32768, 65536, 0, 0, -65536, 0, 65536));
    send_ray(mk_ray(32768, 32768, 65536, 65536, 0, 0, 0, 65536));
    send_ray(mk_ray(0, 0, 0, 0, 0, 1, -64'sd2147483648, 64'sd2147483647));
    send_ray(mk_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                    -64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                    -64'sd2147483648, 64'sd2147483647));
    send_ray(mk_ray(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                    64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                    -64'sd2147483648, 64'sd2147483647));
    send_ray(mk_ray(32768, 32768, 65536, 0, 0, -65536, 2 << 16, 0));
    drain();
  endtask

  task automatic test_axes_and_flip;
    // each plane orientation plus the unused axis code, flipped on the odd axis codes
    for (int ax = 0; ax < 4; ax++) begin
      set_rect(2'(ax), 65536, -65536, 65536, -65536, 65536, 1'(ax & 1), 16'hFFFF);
      for (int i = 0; i < 3; i++) send_ray(aimed_ray());
      drain();
    end
    // degenerate and full-width ranges, extreme offset
    set_rect(AXIS_Z, -64'sd2147483648, 0, 0, -64'sd2147483648, 64'sd2147483647, 1'b0, 0);
    for (int i = 0; i < 3; i++) send_ray(aimed_ray());
    drain();
  endtask

  task automatic test_random_traffic;
    int idle_s[4] = '{0, 63, 0, 13};
    int idle_r[4] = '{0, 0, 63, 13};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_s[ph];
      recv_stall_pct = idle_r[ph];
      for (int c = 0; c < 4; c++) begin
        random_rect();
        for (int i = 0; i < 60; i++)
          send_ray(($urandom_range(9) < 7) ? aimed_ray() : noise_ray());
        // hold off until every pending result has arrived
        drain();
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rect_axis = AXIS_Z; rect_ofs = 0;
    rect_la = 0; rect_ha = 65536; rect_lb = 0; rect_hb = 65536;
    rect_flip = 1'b0; rect_mat = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_axes_and_flip();
    test_random_traffic();
    if (errors == 0) $display("PASS ray_rectangle_intersect");
    else $display("FAIL ray_rectangle_intersect");
    $finish;
  end

endmodule
